// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file mts_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mts_pkg.sv =====
// Package for the min-tracking stack: widths, codes, state type and the top decode.
// No dependencies.
package mts_pkg;

   localparam int STACK_DEPTH_DEF = 256;
   localparam int VALUE_W         = 32;
   localparam int WORD_W          = 34;
   localparam int STATUS_W        = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOAD
   } state_type;

   // A stored word below the minimum marks a minimum push; the top is then the minimum.
   function automatic logic signed [VALUE_W-1:0] decode_top(
      input logic signed [WORD_W-1:0]  word,
      input logic signed [VALUE_W-1:0] min_val
   );
      logic signed [WORD_W-1:0] min_ext;
      min_ext = {{(WORD_W-VALUE_W){min_val[VALUE_W-1]}}, min_val};
      if (word < min_ext) begin
         return min_val;
      end
      return word[VALUE_W-1:0];
   endfunction

endpackage

// ===== rtl/mts_ram.sv =====
// Stack entry memory: one write port, one read port, registered read data.
// Uses mts_pkg.
module mts_ram #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF,
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ADDR_W-1:0]               wr_addr,
   input  logic [mts_pkg::WORD_W-1:0]      wr_data,
   input  logic                            rd_en,
   input  logic [ADDR_W-1:0]               rd_addr,
   output logic [mts_pkg::WORD_W-1:0]      rd_data
);

   logic [mts_pkg::WORD_W-1:0] mem [STACK_DEPTH];
   logic [mts_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/min_tracking_stack.sv =====
// Min-tracking stack of signed 32-bit values; entries in mts_ram, uses mts_pkg.
// Push, error and pop-to-empty requests: result registered in the cycle after acceptance,
// next request taken once the result is taken or gone. Pop leaving entries: the new top word is
// fetched into the memory read register, then decoded in ST_LOAD into the result registers.
// Throughput: one push per cycle while results are taken; no request is taken in ST_LOAD.
// Synchronous active-high reset empties the stack and zeroes the minimum; memory is not cleared.
module min_tracking_stack #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF,
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic signed [mts_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [mts_pkg::VALUE_W-1:0] rsp_top_value,
   output logic signed [mts_pkg::VALUE_W-1:0] rsp_min_value,
   output logic [CNT_W-1:0]                   rsp_depth,
   output logic [mts_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int VW = mts_pkg::VALUE_W;
   localparam int WW = mts_pkg::WORD_W;

   mts_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [VW-1:0] min_ff, min_in;
   logic signed [WW-1:0] top_word_ff, top_word_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0] rsp_top_ff, rsp_top_in;
   logic signed [VW-1:0] rsp_min_ff, rsp_min_in;
   logic [CNT_W-1:0]     rsp_depth_ff, rsp_depth_in;
   logic [mts_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic accept, is_empty, is_full, is_pop, pop_fetch;
   logic signed [WW-1:0] value_ext, min_ext, push_word;
   logic [CNT_W-1:0] count_m2;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [WW-1:0]     rd_data;

   assign accept    = req_valid && req_ready;
   assign is_pop    = (req_op == mts_pkg::OP_POP);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(STACK_DEPTH));
   assign count_m2  = count_ff - CNT_W'(2);
   assign pop_fetch = accept && is_pop && (count_ff > CNT_W'(1));

   assign value_ext = {{(WW-VW){req_value[VW-1]}}, req_value};
   assign min_ext   = {{(WW-VW){min_ff[VW-1]}}, min_ff};
   assign push_word = (is_empty || (req_value > min_ff)) ? value_ext
                    : ({req_value[VW-1], req_value, 1'b0} - min_ext);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mts_pkg::ST_IDLE: begin
            if (pop_fetch) begin
               state_in = mts_pkg::ST_LOAD;
            end
         end
         mts_pkg::ST_LOAD: state_in = mts_pkg::ST_IDLE;
         default:          state_in = mts_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         mts_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            rd_en     = pop_fetch;
         end
         mts_pkg::ST_LOAD: req_ready = 1'b0;
         default:          req_ready = 1'b0;
      endcase
   end

   assign rd_addr = count_m2[ADDR_W-1:0];
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_en   = accept && !is_pop && !is_full;

   // datapath
   always_comb begin
      count_in      = count_ff;
      min_in        = min_ff;
      top_word_in   = top_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_top_in    = rsp_top_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      if (state_ff == mts_pkg::ST_LOAD) begin
         top_word_in   = rd_data;
         rsp_valid_in  = 1'b1;
         rsp_top_in    = mts_pkg::decode_top(rd_data, min_ff);
         rsp_min_in    = min_ff;
         rsp_depth_in  = count_ff;
         rsp_status_in = mts_pkg::STATUS_OK;
      end else if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = mts_pkg::STATUS_OK;
         if (!is_pop) begin
            if (is_full) begin
               rsp_status_in = mts_pkg::STATUS_FULL;
               rsp_top_in    = mts_pkg::decode_top(top_word_ff, min_ff);
               rsp_min_in    = min_ff;
            end else begin
               top_word_in = push_word;
               if (is_empty || (req_value <= min_ff)) begin
                  min_in = req_value;
               end
               count_in   = count_ff + CNT_W'(1);
               rsp_top_in = req_value;
               rsp_min_in = (is_empty || (req_value <= min_ff)) ? req_value : min_ff;
            end
            rsp_depth_in = (is_full) ? count_ff : count_ff + CNT_W'(1);
         end else if (is_empty) begin
            rsp_status_in = mts_pkg::STATUS_EMPTY;
            rsp_top_in    = '0;
            rsp_min_in    = '0;
            rsp_depth_in  = '0;
         end else begin
            if (top_word_ff < min_ext) begin
               min_in = VW'({min_ff[VW-1], min_ff, 1'b0} - top_word_ff);
            end
            count_in     = count_ff - CNT_W'(1);
            rsp_top_in   = '0;
            rsp_min_in   = '0;
            rsp_depth_in = '0;
            // a pop leaving entries reports from ST_LOAD, after the fetch
            rsp_valid_in = !pop_fetch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mts_pkg::ST_IDLE;
         count_ff     <= '0;
         min_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_word_ff   <= top_word_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   mts_ram #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== rtl/mts_checker.sv =====
// Port-level checker for min_tracking_stack, bound to the top level.
// Uses mts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mts_checker #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF,
   localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [mts_pkg::VALUE_W-1:0] rsp_top_value,
   input logic signed [mts_pkg::VALUE_W-1:0] rsp_min_value,
   input logic [CNT_W-1:0]                   rsp_depth,
   input logic [mts_pkg::STATUS_W-1:0]       rsp_status
);

   `MTS_ASSERT_IMP(a_empty_err_depth, clock, reset, rsp_valid && (rsp_status == mts_pkg::STATUS_EMPTY), rsp_depth == '0, "pop-on-empty request with nonzero depth")
   `MTS_ASSERT_IMP(a_full_err_depth, clock, reset, rsp_valid && (rsp_status == mts_pkg::STATUS_FULL), rsp_depth == CNT_W'(STACK_DEPTH), "push-on-full request below full depth")
   `MTS_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && (rsp_depth == '0), (rsp_top_value == '0) && (rsp_min_value == '0), "empty stack reports nonzero top or minimum")
   `MTS_ASSERT_IMP(a_top_ge_min, clock, reset, rsp_valid && (rsp_depth != '0), rsp_top_value >= rsp_min_value, "top below minimum")
   `MTS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_top_value) && $stable(rsp_min_value) && $stable(rsp_depth) && $stable(rsp_status), "stalled result changed")

endmodule

bind min_tracking_stack mts_checker #(
   .STACK_DEPTH(STACK_DEPTH)
) u_mts_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_top_value (rsp_top_value),
   .rsp_min_value (rsp_min_value),
   .rsp_depth     (rsp_depth),
   .rsp_status    (rsp_status)
);

// ===== bench/min_tracking_stack_test.sv =====
// Self-checking bench for min_tracking_stack: push/pop requests against a shadow stack model.
// Depends on mts_pkg and the min_tracking_stack RTL only.
module min_tracking_stack_test;

   localparam int DEPTH_W   = $clog2(mts_pkg::STACK_DEPTH_DEF + 1);
   localparam int ITEM_GOAL = 1250;
   localparam int VW        = mts_pkg::VALUE_W;
   localparam int WW        = mts_pkg::WORD_W;
   localparam int DEPTH_MAX = mts_pkg::STACK_DEPTH_DEF;

   typedef struct {
      logic                 op;
      logic signed [VW-1:0] value;
   } stack_request_type;

   typedef struct {
      logic signed [VW-1:0]   top_value;
      logic signed [VW-1:0]   min_value;
      logic [DEPTH_W-1:0]     depth;
      mts_pkg::status_type    status;
   } stack_snapshot_type;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_op    = mts_pkg::OP_PUSH;
   logic signed [VW-1:0]        req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [VW-1:0]        rsp_top_value;
   logic signed [VW-1:0]        rsp_min_value;
   logic [DEPTH_W-1:0]          rsp_depth;
   logic [mts_pkg::STATUS_W-1:0] rsp_status;

   stack_request_type  queued_requests[$];
   stack_snapshot_type awaited_snapshots[$];

   // shadow of the block's state
   logic signed [WW-1:0] shadow_words [DEPTH_MAX];
   logic signed [VW-1:0] shadow_min   = '0;
   logic [DEPTH_W-1:0]   shadow_count = '0;

   int mismatch_count  = 0;
   int accepted_count  = 0;
   int results_seen    = 0;
   int hold_left       = 0;
   int results_to_hold = 300;
   int planned_depth   = 0;

   min_tracking_stack i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_top_value (rsp_top_value),
      .rsp_min_value (rsp_min_value),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status)
   );

   always #5 clock = ~clock;

   // Applies one request to the shadow stack and returns the state reported after it.
   function automatic stack_snapshot_type apply_stack_request(input logic op,
                                                              input logic signed [VW-1:0] value);
      longint             word;
      longint             wide_min;
      stack_snapshot_type snap;
      snap.status = mts_pkg::STATUS_OK;
      wide_min    = shadow_min;
      if (op == mts_pkg::OP_PUSH) begin
         if (shadow_count >= DEPTH_MAX) begin
            snap.status = mts_pkg::STATUS_FULL;
         end else begin
            if (shadow_count != 0 && value <= shadow_min) begin
               word = 2 * longint'(value) - wide_min;
               shadow_words[shadow_count] = word[WW-1:0];
               shadow_min = value;
            end else begin
               shadow_words[shadow_count] = value;
               if (shadow_count == 0) begin
                  shadow_min = value;
               end
            end
            shadow_count = shadow_count + 1'b1;
         end
      end else if (shadow_count == 0) begin
         snap.status = mts_pkg::STATUS_EMPTY;
      end else begin
         word = shadow_words[shadow_count - 1'b1];
         // marker word: rebuild the previous minimum
         if (word < wide_min) begin
            wide_min   = 2 * wide_min - word;
            shadow_min = wide_min[VW-1:0];
         end
         shadow_count = shadow_count - 1'b1;
      end
      if (shadow_count != 0) begin
         word     = shadow_words[shadow_count - 1'b1];
         wide_min = shadow_min;
         snap.top_value = (word < wide_min) ? shadow_min : word[VW-1:0];
         snap.min_value = shadow_min;
      end else begin
         snap.top_value = '0;
         snap.min_value = '0;
      end
      snap.depth = shadow_count;
      return snap;
   endfunction

   task automatic report_mismatch(input string note);
      $display("ERROR at %0t: %s", $realtime, note);
      mismatch_count++;
   endtask

   task automatic plan_request(input logic op, input logic signed [VW-1:0] value);
      stack_request_type r;
      r.op    = op;
      r.value = value;
      queued_requests.push_back(r);
      if (op == mts_pkg::OP_PUSH && planned_depth < DEPTH_MAX) begin
         planned_depth++;
      end else if (op == mts_pkg::OP_POP && planned_depth > 0) begin
         planned_depth--;
      end
   endtask

   function automatic logic signed [VW-1:0] pick_value();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         // narrow band so that equal and lower pushes are frequent
         1, 2, 3, 4: return int'($urandom_range(40)) - 20;
         default: return $urandom;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_snapshots.push_back(apply_stack_request(req_op, req_value));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (queued_requests.size() != 0 &&
                ((accepted_count >= 500 && accepted_count < 750) ||
                 $urandom_range(99) >= 24)) begin
               req_valid <= 1'b1;
               req_op    <= queued_requests[0].op;
               req_value <= queued_requests[0].value;
               void'(queued_requests.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off once, so the block backs up and stalls its input
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (rsp_valid && rsp_ready) begin
            if (results_to_hold == 1) begin
               hold_left <= 160;
            end
            results_to_hold--;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      stack_snapshot_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_snapshots.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none awaited", results_seen));
            end else begin
               want = awaited_snapshots.pop_front();
               if (rsp_top_value !== want.top_value)
                  report_mismatch($sformatf("result %0d top_value %0d, want %0d",
                                            results_seen, rsp_top_value, want.top_value));
               if (rsp_min_value !== want.min_value)
                  report_mismatch($sformatf("result %0d min_value %0d, want %0d",
                                            results_seen, rsp_min_value, want.min_value));
               if (rsp_depth !== want.depth)
                  report_mismatch($sformatf("result %0d depth %0d, want %0d",
                                            results_seen, rsp_depth, want.depth));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("result %0d status %0d, want %0d",
                                            results_seen, rsp_status, want.status));
            end
            results_seen++;
         end
         rsp_ready <= (hold_left == 0) &&
                      ((results_seen >= 500 && results_seen < 750) ||
                       $urandom_range(99) >= 24);
      end
   end

   initial begin
      int push_pct;
      int run_len;
      bit filled;
      filled = 1'b0;

      // directed: empty pops, extremes, equal-to-minimum pushes, minimum rebuild
      plan_request(mts_pkg::OP_POP,  32'sd5);
      plan_request(mts_pkg::OP_PUSH, 32'sd0);
      plan_request(mts_pkg::OP_PUSH, 32'sd0);
      plan_request(mts_pkg::OP_PUSH, 32'sh7fff_ffff);
      plan_request(mts_pkg::OP_PUSH, 32'sh8000_0000);
      plan_request(mts_pkg::OP_PUSH, 32'sh8000_0000);
      plan_request(mts_pkg::OP_PUSH, 32'sh7fff_ffff);
      plan_request(mts_pkg::OP_POP,  32'sh7fff_ffff);
      plan_request(mts_pkg::OP_POP,  32'sd0);
      plan_request(mts_pkg::OP_POP,  -32'sd1);
      plan_request(mts_pkg::OP_POP,  32'sd0);
      plan_request(mts_pkg::OP_POP,  32'sd0);
      plan_request(mts_pkg::OP_POP,  32'sd0);
      plan_request(mts_pkg::OP_POP,  32'sd0);
      // minimum left over from before must be replaced by the next first push
      plan_request(mts_pkg::OP_PUSH, 32'sh7fff_ffff);
      plan_request(mts_pkg::OP_PUSH, 32'sh8000_0000);
      plan_request(mts_pkg::OP_PUSH, -32'sd1);
      plan_request(mts_pkg::OP_PUSH, 32'sh8000_0001);
      plan_request(mts_pkg::OP_POP,  32'sh5555_5555);
      plan_request(mts_pkg::OP_POP,  32'shaaaa_aaaa);
      plan_request(mts_pkg::OP_POP,  32'sd0);
      plan_request(mts_pkg::OP_POP,  32'sd0);
      plan_request(mts_pkg::OP_POP,  32'sd0);

      while (queued_requests.size() < ITEM_GOAL) begin
         if (!filled && queued_requests.size() > 350) begin
            // fill to the top, push on full, churn at the top, then drain past empty
            while (planned_depth < DEPTH_MAX) begin
               plan_request(mts_pkg::OP_PUSH, pick_value());
            end
            repeat ($urandom_range(4, 8)) plan_request(mts_pkg::OP_PUSH, pick_value());
            repeat (6) begin
               plan_request(mts_pkg::OP_POP,  pick_value());
               plan_request(mts_pkg::OP_PUSH, pick_value());
               plan_request(mts_pkg::OP_PUSH, pick_value());
            end
            while (planned_depth > 0) begin
               plan_request(mts_pkg::OP_POP, pick_value());
            end
            repeat (3) plan_request(mts_pkg::OP_POP, pick_value());
            filled = 1'b1;
         end else begin
            case ($urandom_range(2))
               0: push_pct = 30;
               1: push_pct = 55;
               default: push_pct = 75;
            endcase
            run_len = $urandom_range(30, 90);
            repeat (run_len) begin
               plan_request(($urandom_range(99) < push_pct) ? mts_pkg::OP_PUSH : mts_pkg::OP_POP,
                            pick_value());
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || awaited_snapshots.size() != 0);
      repeat (10) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("min_tracking_stack: match");
      end else begin
         $display("min_tracking_stack: mismatch");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("min_tracking_stack: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/min_tracking_stack.sv
rtl/mts_checker.sv
bench/min_tracking_stack_test.sv
